// File: hw/rtl/c_clb_pkg.sv
// c_clb_pkg: lexer modes and character codes for the comment/literal blanker.
// No dependencies.
`timescale 1ns / 1ps

package c_clb_pkg;

    typedef enum logic [1:0] {
        MODE_CODE  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_BLOCK = 2'd2,
        MODE_LIT   = 2'd3
    } lex_mode_t;

    typedef logic [7:0] char_t;

    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_NL    = 8'h0A;
    localparam char_t CH_SLASH = 8'h2F;
    localparam char_t CH_STAR  = 8'h2A;
    localparam char_t CH_BSL   = 8'h5C;
    localparam char_t CH_DQ    = 8'h22;
    localparam char_t CH_SQ    = 8'h27;

    localparam int unsigned OBUF_DEPTH = 4;
    localparam int unsigned OBUF_AW    = 2;
    localparam int unsigned OBUF_CW    = 3;

endpackage

// File: hw/rtl/c_comment_literal_blanker_core.sv
// c_comment_literal_blanker_core: blanks C comments and literals in a byte stream.
// Depends on c_clb_pkg.
`timescale 1ns / 1ps

// Usage:
//   Slave channel s_*: one source byte per transaction in s_tdata, s_tlast on the
//   final byte of a text. Master channel m_*: cleaned bytes, same total count as
//   the input, m_tlast on the last cleaned byte of the text.
//   Comments and string/char literals come out as spaces; newlines are kept.
//   A '/' in code is held one byte to detect a comment start, so one input
//   transaction yields zero, one or two output transactions.
// Results: each result is registered into the output buffer and presented on m_*
//   from there (a held slash goes out with the following byte).
// Throughput: one byte per cycle while s_tready is high. Results land in a four-entry
//   output buffer; s_tready is high while at least two entries are free, so a stalled
//   receiver backs the input up and nothing is dropped.
// Reset: aresetn (synchronous, active low) empties the buffer and returns the
//   lexer to plain code. After a byte with s_tlast the lexer also returns to
//   plain code, so the next byte starts a new text.
module c_comment_literal_blanker_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] src_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // final_out
);
    import c_clb_pkg::*;

    lex_mode_t mode_reg, mode_next;
    logic star_reg, star_next;
    logic esc_reg, esc_next;
    logic dq_reg, dq_next;
    logic slash_reg, slash_next;

    logic [8:0] obuf_reg [OBUF_DEPTH];
    logic [OBUF_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OBUF_CW-1:0] count_reg;

    logic s_fire, m_fire;
    char_t c, b0, b1, code_val, quote_ch;
    logic  last, code_put, f0, f1;
    logic [1:0] n;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign c      = s_tdata;
    assign last   = s_tlast;

    assign s_tready = (count_reg <= OBUF_CW'(OBUF_DEPTH - 2));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = obuf_reg[rd_ptr_reg][7:0];
    assign m_tlast  = obuf_reg[rd_ptr_reg][8];

    // plain-code handling of one byte, with or without a slash pending
    assign code_put = !(c == CH_SLASH && !last);
    assign code_val = (c == CH_DQ || c == CH_SQ) ? CH_SPACE : c;
    assign quote_ch = dq_reg ? CH_DQ : CH_SQ;

    always_comb begin
        mode_next  = mode_reg;
        star_next  = star_reg;
        esc_next   = esc_reg;
        dq_next    = dq_reg;
        slash_next = slash_reg;
        b0 = CH_SPACE;
        b1 = CH_SPACE;
        n  = 2'd1;
        case (mode_reg)
            MODE_CODE: begin
                if (slash_reg && (c == CH_SLASH || c == CH_STAR)) begin
                    slash_next = 1'b0;
                    n          = 2'd2;
                    mode_next  = (c == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                    star_next  = 1'b0;
                end else begin
                    if (slash_reg) begin
                        b0 = CH_SLASH;
                        b1 = code_val;
                        n  = code_put ? 2'd2 : 2'd1;
                    end else begin
                        b0 = code_val;
                        n  = code_put ? 2'd1 : 2'd0;
                    end
                    slash_next = !code_put;
                    if (c == CH_DQ || c == CH_SQ) begin
                        mode_next = MODE_LIT;
                        dq_next   = (c == CH_DQ);
                        esc_next  = 1'b0;
                    end
                end
            end
            MODE_LINE: begin
                if (c == CH_NL) begin
                    b0        = CH_NL;
                    mode_next = MODE_CODE;
                end
            end
            MODE_BLOCK: begin
                if (star_reg && c == CH_SLASH) begin
                    mode_next = MODE_CODE;
                    star_next = 1'b0;
                end else if (c == CH_NL) begin
                    b0        = CH_NL;
                    star_next = 1'b0;
                end else begin
                    star_next = (c == CH_STAR);
                end
            end
            MODE_LIT: begin
                if (esc_reg) begin
                    b0       = (c == CH_NL) ? CH_NL : CH_SPACE;
                    esc_next = 1'b0;
                end else if (c == quote_ch) begin
                    mode_next = MODE_CODE;
                end else if (c == CH_BSL) begin
                    esc_next = 1'b1;
                end else if (c == CH_NL) begin
                    b0        = CH_NL;
                    mode_next = MODE_CODE;
                end
            end
            default: begin
                mode_next = MODE_CODE;
            end
        endcase
        if (last) begin
            mode_next  = MODE_CODE;
            star_next  = 1'b0;
            esc_next   = 1'b0;
            dq_next    = 1'b0;
            slash_next = 1'b0;
        end
    end

    assign f0 = last && (n == 2'd1);
    assign f1 = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_CODE;
            star_reg   <= 1'b0;
            esc_reg    <= 1'b0;
            dq_reg     <= 1'b0;
            slash_reg  <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_fire) begin
                mode_reg   <= mode_next;
                star_reg   <= star_next;
                esc_reg    <= esc_next;
                dq_reg     <= dq_next;
                slash_reg  <= slash_next;
                wr_ptr_reg <= wr_ptr_reg + OBUF_AW'(n);
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (s_fire ? OBUF_CW'(n) : '0)
                                   - (m_fire ? OBUF_CW'(1) : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && n != 2'd0) begin
            obuf_reg[wr_ptr_reg] <= {f0, b0};
        end
        if (s_fire && n == 2'd2) begin
            obuf_reg[wr_ptr_reg + 1'b1] <= {f1, b1};
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OBUF_CW'(OBUF_DEPTH))
        else $error("output buffer overflow");

    a_slash_in_code: assert property (@(posedge aclk) disable iff (!aresetn)
        slash_reg |-> (mode_reg == MODE_CODE))
        else $error("slash held outside plain code");

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (mode_reg == MODE_CODE && !slash_reg && !esc_reg))
        else $error("lexer state not cleared after last byte");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        OBUF_AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[OBUF_AW-1:0])
        else $error("buffer pointers disagree with count");

    a_esc_in_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg |-> (mode_reg == MODE_LIT))
        else $error("escape pending outside literal");

endmodule
